// ----- hw/rtl/tsvf_pkg.sv -----
// Shared types, register indexes and the step program of the shelf filter sequencer.
package tsvf_pkg;

    // Coefficient and configuration port widths
    localparam int COEF_W    = 32;
    localparam int NORM_W    = 31;
    localparam int CFG_IDX_W = 8;

    // Multiplier split: operand magnitude is cut into two 32-bit halves
    localparam int HALF_W = 32;
    localparam int MAG_W  = 2 * HALF_W;

    // Product scaling for Q4.28 and Q2.30 coefficients
    localparam int SH_Q28 = 28;
    localparam int SH_Q30 = 30;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_GAIN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_TWICE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALISER    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELF_AMOUNT  = 8'd3;

    // Configuration reset values
    localparam logic [COEF_W-1:0] RST_CUTOFF_GAIN   = 32'd0;
    localparam logic [COEF_W-1:0] RST_DAMPING_TWICE = 32'd379625062;
    localparam logic [NORM_W-1:0] RST_NORMALISER    = 31'd1073741824;
    localparam logic [COEF_W-1:0] RST_SHELF_AMOUNT  = 32'd268435456;

    // Step program counter
    localparam int                PC_W      = 5;
    localparam logic [PC_W-1:0]   LAST_STEP = 5'd17;

    // Datapath working registers
    typedef enum logic [2:0] {
        R_X  = 3'd0,
        R_S1 = 3'd1,
        R_S2 = 3'd2,
        R_T  = 3'd3,
        R_HP = 3'd4,
        R_BP = 3'd5,
        R_LP = 3'd6,
        R_Y  = 3'd7
    } t_reg;

    // Coefficient select for the multiplier
    typedef enum logic [1:0] {
        C_G  = 2'd0,
        C_R2 = 2'd1,
        C_D  = 2'd2,
        C_M2 = 2'd3
    } t_coef;

    // One step of the program: a scaled multiply or a saturating add/sub
    typedef struct packed {
        logic  is_mul;
        t_reg  src_a;
        t_reg  src_b;
        logic  sub;
        t_coef coef;
        t_reg  dst;
    } t_uop;

    // Coefficient set from the configuration registers
    typedef struct packed {
        logic [COEF_W-1:0] g;
        logic [COEF_W-1:0] r2;
        logic [NORM_W-1:0] d;
        logic [COEF_W-1:0] m2;
    } t_coefs;

    // Command bundle from the controller to the datapath
    typedef struct packed {
        logic load_x;
        logic mul_lo;
        logic mul_hi;
        logic mul_wb;
        logic alu_wb;
        logic out_wb;
        t_uop uop;
    } t_dp_cmd;

    function automatic t_uop mk_mul(input t_reg src, input t_coef coef, input t_reg dst);
        t_uop u;
        u.is_mul = 1'b1;
        u.src_a  = src;
        u.src_b  = R_X;
        u.sub    = 1'b0;
        u.coef   = coef;
        u.dst    = dst;
        return u;
    endfunction

    function automatic t_uop mk_alu(input t_reg a, input t_reg b, input logic sub,
                                    input t_reg dst);
        t_uop u;
        u.is_mul = 1'b0;
        u.src_a  = a;
        u.src_b  = b;
        u.sub    = sub;
        u.coef   = C_G;
        u.dst    = dst;
        return u;
    endfunction

    // Filter program: feedback, highpass, two integrators, shelf mix
    function automatic t_uop step_uop(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            5'd0:    u = mk_mul(R_S1, C_R2, R_T);           // 2R * s1
            5'd1:    u = mk_mul(R_S1, C_G, R_Y);            // g * s1
            5'd2:    u = mk_alu(R_T, R_Y, 1'b0, R_T);       // feedback
            5'd3:    u = mk_alu(R_X, R_T, 1'b1, R_T);       // x - feedback
            5'd4:    u = mk_alu(R_T, R_S2, 1'b1, R_T);      // minus s2
            5'd5:    u = mk_mul(R_T, C_D, R_HP);            // highpass
            5'd6:    u = mk_mul(R_HP, C_G, R_T);            // v1
            5'd7:    u = mk_alu(R_T, R_S1, 1'b0, R_BP);     // bandpass
            5'd8:    u = mk_alu(R_BP, R_T, 1'b0, R_S1);     // first integrator
            5'd9:    u = mk_mul(R_BP, C_G, R_T);            // v2
            5'd10:   u = mk_alu(R_T, R_S2, 1'b0, R_LP);     // lowpass
            5'd11:   u = mk_alu(R_LP, R_T, 1'b0, R_S2);     // second integrator
            5'd12:   u = mk_mul(R_BP, C_R2, R_T);           // 2R * bp
            5'd13:   u = mk_mul(R_T, C_M2, R_T);            // m2 * 2R * bp
            5'd14:   u = mk_alu(R_LP, R_T, 1'b0, R_Y);      // lp + band term
            5'd15:   u = mk_mul(R_HP, C_M2, R_T);           // m2 * hp
            5'd16:   u = mk_mul(R_T, C_M2, R_T);            // m2 * m2 * hp
            5'd17:   u = mk_alu(R_Y, R_T, 1'b0, R_Y);       // add high term
            default: u = mk_alu(R_Y, R_T, 1'b0, R_Y);
        endcase
        return u;
    endfunction

endpackage

// ----- hw/rtl/tsvf_cfg_regs.sv -----
// Coefficient configuration registers of the shelf filter.
module tsvf_cfg_regs
    import tsvf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output t_coefs               o_coefs
);

    t_coefs r_coefs;

    // Always take a write beat
    assign o_cfg_ready = 1'b1;

    // Decode the index; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.g  <= RST_CUTOFF_GAIN;
            r_coefs.r2 <= RST_DAMPING_TWICE;
            r_coefs.d  <= RST_NORMALISER;
            r_coefs.m2 <= RST_SHELF_AMOUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CUTOFF_GAIN:   r_coefs.g  <= i_cfg_data;
                CFG_DAMPING_TWICE: r_coefs.r2 <= i_cfg_data;
                CFG_NORMALISER:    r_coefs.d  <= i_cfg_data[NORM_W-1:0];
                CFG_SHELF_AMOUNT:  r_coefs.m2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

// ----- hw/rtl/tsvf_dp.sv -----
// Datapath: working registers, shared split multiplier, saturating adder, format conversion.
module tsvf_dp
    import tsvf_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int STATE_BITS  = 48
)
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  t_coefs                        i_coefs,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int STATE_FRAC  = STATE_BITS - 8;
    localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;

    localparam logic signed [STATE_BITS-1:0] ST_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] ST_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Input conversion: sample format to state format
    localparam int IN_UP = (STATE_FRAC >= SAMPLE_FRAC) ? STATE_FRAC - SAMPLE_FRAC : 0;
    localparam int IN_DN = (SAMPLE_FRAC > STATE_FRAC) ? SAMPLE_FRAC - STATE_FRAC : 0;
    localparam int IN_W  = SAMPLE_BITS + 1 + IN_UP;
    localparam int IN_CW = ((IN_W > STATE_BITS) ? IN_W : STATE_BITS) + 1;
    localparam logic [IN_W-1:0]  IN_RND = IN_W'((64'd1 << IN_DN) >> 1);
    localparam logic [IN_CW-1:0] IN_LIM = IN_CW'(1) << (STATE_BITS - 1);

    // Output conversion: state format to sample format
    localparam int OUT_UP = (SAMPLE_FRAC >= STATE_FRAC) ? SAMPLE_FRAC - STATE_FRAC : 0;
    localparam int OUT_DN = (STATE_FRAC > SAMPLE_FRAC) ? STATE_FRAC - SAMPLE_FRAC : 0;
    localparam int OUT_W  = STATE_BITS + 1 + OUT_UP;
    localparam int OUT_CW = ((OUT_W > SAMPLE_BITS) ? OUT_W : SAMPLE_BITS) + 1;
    localparam logic [OUT_W-1:0]  OUT_RND = OUT_W'((64'd1 << OUT_DN) >> 1);
    localparam logic [OUT_CW-1:0] OUT_LIM = OUT_CW'(1) << (SAMPLE_BITS - 1);

    // Product combine
    localparam int SUM_W = MAG_W + COEF_W + 1;
    localparam logic [SUM_W-1:0] RND_Q28 = SUM_W'(1) << (SH_Q28 - 1);
    localparam logic [SUM_W-1:0] RND_Q30 = SUM_W'(1) << (SH_Q30 - 1);
    localparam logic [SUM_W-1:0] MUL_LIM = SUM_W'(1) << (STATE_BITS - 1);

    logic signed [STATE_BITS-1:0] r_x, r_s1, r_s2, r_t, r_hp, r_bp, r_lp, r_y;
    logic [MAG_W-1:0]             r_plo, r_phi;
    logic                         r_mneg;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;

    logic signed [STATE_BITS-1:0] opa, opb;
    logic [COEF_W-1:0]            coef;
    logic                         sh30;

    // Select operands
    always_comb begin
        case (i_cmd.uop.src_a)
            R_X:     opa = r_x;
            R_S1:    opa = r_s1;
            R_S2:    opa = r_s2;
            R_T:     opa = r_t;
            R_HP:    opa = r_hp;
            R_BP:    opa = r_bp;
            R_LP:    opa = r_lp;
            R_Y:     opa = r_y;
            default: opa = r_y;
        endcase
        case (i_cmd.uop.src_b)
            R_X:     opb = r_x;
            R_S1:    opb = r_s1;
            R_S2:    opb = r_s2;
            R_T:     opb = r_t;
            R_HP:    opb = r_hp;
            R_BP:    opb = r_bp;
            R_LP:    opb = r_lp;
            R_Y:     opb = r_y;
            default: opb = r_y;
        endcase
        case (i_cmd.uop.coef)
            C_G:     coef = i_coefs.g;
            C_R2:    coef = i_coefs.r2;
            C_D:     coef = {1'b0, i_coefs.d};
            C_M2:    coef = i_coefs.m2;
            default: coef = i_coefs.m2;
        endcase
        sh30 = (i_cmd.uop.coef == C_D);
    end

    // Operand magnitude, split into halves for the 32x32 multiplier
    logic [STATE_BITS:0]  a_ext, a_neg;
    logic [MAG_W-1:0]     a_mag;
    logic [HALF_W-1:0]    mul_in;
    logic [MAG_W-1:0]     prod;

    assign a_ext  = {opa[STATE_BITS-1], opa};
    assign a_neg  = '0 - a_ext;
    assign a_mag  = MAG_W'(opa[STATE_BITS-1] ? a_neg[STATE_BITS-1:0] : a_ext[STATE_BITS-1:0]);
    assign mul_in = i_cmd.mul_hi ? a_mag[MAG_W-1:HALF_W] : a_mag[HALF_W-1:0];
    assign prod   = MAG_W'(mul_in) * MAG_W'(coef);

    // Hold partial products
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_plo  <= prod;
            r_mneg <= opa[STATE_BITS-1];
        end
        if (i_cmd.mul_hi) begin
            r_phi <= prod;
        end
    end

    // Combine, round half away from zero, scale and saturate
    logic [SUM_W-1:0]             sum, q, q_neg;
    logic signed [STATE_BITS-1:0] mul_res;

    always_comb begin
        sum   = SUM_W'(r_plo) + (SUM_W'(r_phi) << HALF_W) + (sh30 ? RND_Q30 : RND_Q28);
        q     = sh30 ? (sum >> SH_Q30) : (sum >> SH_Q28);
        q_neg = '0 - q;
        if (r_mneg) begin
            mul_res = (q > MUL_LIM) ? ST_MIN : q_neg[STATE_BITS-1:0];
        end else begin
            mul_res = (q >= MUL_LIM) ? ST_MAX : q[STATE_BITS-1:0];
        end
    end

    // Saturating add/sub
    logic [STATE_BITS:0]          alu_sum;
    logic signed [STATE_BITS-1:0] alu_res;

    always_comb begin
        if (i_cmd.uop.sub) begin
            alu_sum = {opa[STATE_BITS-1], opa} - {opb[STATE_BITS-1], opb};
        end else begin
            alu_sum = {opa[STATE_BITS-1], opa} + {opb[STATE_BITS-1], opb};
        end
        if (alu_sum[STATE_BITS] != alu_sum[STATE_BITS-1]) begin
            alu_res = alu_sum[STATE_BITS] ? ST_MIN : ST_MAX;
        end else begin
            alu_res = alu_sum[STATE_BITS-1:0];
        end
    end

    // Rescale the input sample to the state format
    logic [SAMPLE_BITS:0]         s_ext, s_neg;
    logic [IN_W-1:0]              in_mag, in_m;
    logic [IN_CW-1:0]             in_c, in_c_neg;
    logic signed [STATE_BITS-1:0] x_in;

    always_comb begin
        s_ext    = {i_sample_in[SAMPLE_BITS-1], i_sample_in};
        s_neg    = '0 - s_ext;
        in_mag   = IN_W'(i_sample_in[SAMPLE_BITS-1] ? s_neg[SAMPLE_BITS-1:0]
                                                   : s_ext[SAMPLE_BITS-1:0]);
        in_m     = ((in_mag + IN_RND) >> IN_DN) << IN_UP;
        in_c     = IN_CW'(in_m);
        in_c_neg = '0 - in_c;
        if (i_sample_in[SAMPLE_BITS-1]) begin
            x_in = (in_c > IN_LIM) ? ST_MIN : in_c_neg[STATE_BITS-1:0];
        end else begin
            x_in = (in_c >= IN_LIM) ? ST_MAX : in_c[STATE_BITS-1:0];
        end
    end

    // Rescale the mix to the sample format
    logic [STATE_BITS:0]           y_ext, y_neg;
    logic [OUT_W-1:0]              out_mag, out_m;
    logic [OUT_CW-1:0]             out_c, out_c_neg;
    logic signed [SAMPLE_BITS-1:0] y_out;

    always_comb begin
        y_ext     = {r_y[STATE_BITS-1], r_y};
        y_neg     = '0 - y_ext;
        out_mag   = OUT_W'(r_y[STATE_BITS-1] ? y_neg[STATE_BITS-1:0] : y_ext[STATE_BITS-1:0]);
        out_m     = ((out_mag + OUT_RND) >> OUT_DN) << OUT_UP;
        out_c     = OUT_CW'(out_m);
        out_c_neg = '0 - out_c;
        if (r_y[STATE_BITS-1]) begin
            y_out = (out_c > OUT_LIM) ? SMP_MIN : out_c_neg[SAMPLE_BITS-1:0];
        end else begin
            y_out = (out_c >= OUT_LIM) ? SMP_MAX : out_c[SAMPLE_BITS-1:0];
        end
    end

    // Write back one step result
    logic                         wr_en;
    logic signed [STATE_BITS-1:0] wr_data;

    assign wr_en   = i_cmd.mul_wb | i_cmd.alu_wb;
    assign wr_data = i_cmd.mul_wb ? mul_res : alu_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= x_in;
        end
        if (wr_en) begin
            unique case (i_cmd.uop.dst)
                R_T:     r_t  <= wr_data;
                R_HP:    r_hp <= wr_data;
                R_BP:    r_bp <= wr_data;
                R_LP:    r_lp <= wr_data;
                R_Y:     r_y  <= wr_data;
                default: ;
            endcase
        end
        if (i_cmd.out_wb) begin
            r_sample_out <= y_out;
        end
    end

    // Integrator states clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (wr_en) begin
            if (i_cmd.uop.dst == R_S1) begin
                r_s1 <= wr_data;
            end
            if (i_cmd.uop.dst == R_S2) begin
                r_s2 <= wr_data;
            end
        end
    end

    assign o_sample_out = r_sample_out;

endmodule

// ----- hw/rtl/tsvf_ctrl.sv -----
// Controller: step sequencer over the filter program and output beat handshake.
module tsvf_ctrl
    import tsvf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL_LO = 6'b000010,
        S_MUL_HI = 6'b000100,
        S_MUL_WB = 6'b001000,
        S_ALU    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_out_valid, n_out_valid;
    logic            step_done;
    t_uop            cur_uop, nxt_uop, first_uop;

    assign cur_uop   = step_uop(r_pc);
    assign nxt_uop   = step_uop(r_pc + PC_W'(1));
    assign first_uop = step_uop('0);

    // Sequence states and step counter
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_out_valid = r_out_valid & ~i_out_ready;
        step_done   = 1'b0;
        o_cmd       = '0;
        o_cmd.uop   = cur_uop;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_pc         = '0;
                    n_state      = first_uop.is_mul ? S_MUL_LO : S_ALU;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_MUL_WB;
            end
            S_MUL_WB: begin
                o_cmd.mul_wb = 1'b1;
                step_done    = 1'b1;
            end
            S_ALU: begin
                o_cmd.alu_wb = 1'b1;
                step_done    = 1'b1;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_wb = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Advance to the next step or finish the sample
        if (step_done) begin
            if (r_pc == LAST_STEP) begin
                n_state = S_OUT;
            end else begin
                n_pc    = r_pc + PC_W'(1);
                n_state = nxt_uop.is_mul ? S_MUL_LO : S_ALU;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_MUL_LO || r_state == S_ALU))
        else $error("accepted sample did not start the program");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= LAST_STEP)
        else $error("step counter ran past the program");

    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL_LO |=> r_state == S_MUL_HI)
        else $error("multiply halves out of order");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=> r_state == S_OUT)
        else $error("result register overwritten while occupied");

endmodule

// ----- hw/rtl/tpt_svf_high_shelf_core.sv -----
// Top level of the state-variable high-shelf filter: config registers, controller, datapath.
// Each accepted input beat runs 18 program steps on the one shared 32x32 multiplier:
//   9 multiplies (low half, high half, write-back) and 9 saturating adds, then the output step.
// The sequencer runs one sample through the program at a time and takes no input mid-program;
//   the next input beat is taken while the previous result waits in the output register.
// Reset (synchronous, i_rst_n low): integrators clear to zero, coefficients take their defaults.
// i_last_in_block is carried on the interface only; it does not affect the result.
module tpt_svf_high_shelf_core
    import tsvf_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int STATE_BITS  = 48
)
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_last_in_block,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [COEF_W-1:0]             i_cfg_data
);

    t_coefs  coefs;
    t_dp_cmd cmd;

    tsvf_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs)
    );

    tsvf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    tsvf_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_BITS  (STATE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_coefs      (coefs),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out)
    );

endmodule
